@@ design/bicycle_matrix_column_index_unit_macros.svh @@
// Assertion macros shared by the column index unit RTL.
`ifndef BICYCLE_MATRIX_COLUMN_INDEX_UNIT_MACROS_SVH
`define BICYCLE_MATRIX_COLUMN_INDEX_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BMCI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BMCI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bmci_pkg.sv @@
// Types and constants of the column index unit.
`default_nettype none

package bmci_pkg;

    localparam int ORDER_X_W = 13;
    localparam int ORDER_Y_W = 12;
    localparam int CFG_W     = 13;
    localparam int FUNC_W    = 2;
    localparam int BLOCK_W   = 3;
    localparam int SLOT_W    = 5;
    localparam int VALUE_W   = 12;
    localparam int TOTAL_W   = 6;
    localparam int COORD_W   = 12;
    localparam int COL_W     = 15;
    localparam int IDX_W     = 26;

    typedef enum logic [0:0] {
        REG_ORDER_X = 1'b0,
        REG_ORDER_Y = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FUNC_SKIP_WR  = 2'd0,
        FUNC_SKIP_CNT = 2'd1,
        FUNC_MAP      = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_MUL,
        ST_BASE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Load command into the skip store.
    typedef struct packed {
        logic                list_we;
        logic                count_we;
        logic [BLOCK_W-1:0]  block;
        logic [SLOT_W-1:0]   slot;
        logic [VALUE_W-1:0]  value;
        logic [TOTAL_W-1:0]  total;
    } skip_wr_t;

endpackage

`default_nettype wire

@@ design/bmci_item_if.sv @@
// Input item channel.
`default_nettype none

interface bmci_item_if;
    import bmci_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [BLOCK_W-1:0]   block_col;
    logic [SLOT_W-1:0]    skip_slot;
    logic [VALUE_W-1:0]   skip_value;
    logic [TOTAL_W-1:0]   skip_total;
    logic [COORD_W-1:0]   shift_x;
    logic [COORD_W-1:0]   shift_y;
    logic [COORD_W-1:0]   term_x;
    logic [COORD_W-1:0]   term_y;

    modport source (
        output valid, func, block_col, skip_slot, skip_value, skip_total,
               shift_x, shift_y, term_x, term_y,
        input  ready
    );

    modport sink (
        input  valid, func, block_col, skip_slot, skip_value, skip_total,
               shift_x, shift_y, term_x, term_y,
        output ready
    );
endinterface

`default_nettype wire

@@ design/bmci_result_if.sv @@
// Result channel.
`default_nettype none

interface bmci_result_if;
    import bmci_pkg::*;

    logic               valid;
    logic               ready;
    logic [COL_W-1:0]   column;
    logic               dropped;

    modport source (
        output valid, column, dropped,
        input  ready
    );

    modport sink (
        input  valid, column, dropped,
        output ready
    );
endinterface

`default_nettype wire

@@ design/bicycle_matrix_column_index_unit.sv @@
// Top level of the bicycle matrix column index unit.
`default_nettype none
`include "bicycle_matrix_column_index_unit_macros.svh"

// Maps one polynomial term of a two-generator quasi-cyclic check matrix to its
// global column, and takes load items that fill the per-block sorted skip lists
// and skip counts. One item is worked on at a time. A load item goes straight to
// the done state, and its (zero) result then moves to the output register. A map item
// first runs two remainder units, which retire one dividend bit per cycle while the
// skip counts of earlier blocks are summed; a multiply state and a base state follow;
// then the block's skip list is scanned with one memory read per cycle; a hit on
// the list ends the scan early. The next item is accepted once the result has moved
// to the output register, while that result still waits to be taken.
module bicycle_matrix_column_index_unit #(
    parameter int BLOCK_COLS = 8,
    parameter int MAX_SKIP   = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [0:0]                 cfg_index,
    input  wire logic [bmci_pkg::CFG_W-1:0] cfg_data,
    bmci_item_if.sink                       item,
    bmci_result_if.source                   result
);
    import bmci_pkg::*;

    localparam int CW = $clog2(MAX_SKIP + 1);
    localparam int SW = CW + BLOCK_W;

    state_t                state_reg, state_next;
    logic [ORDER_X_W-1:0]  order_x_reg;
    logic [ORDER_Y_W-1:0]  order_y_reg;
    logic [BLOCK_W-1:0]    blk_reg, blk_next;
    logic [BLOCK_W-1:0]    sum_blk_reg, sum_blk_next;
    logic [SW-1:0]         sum_reg, sum_next;
    logic [COL_W-1:0]      ell_reg, ell_next;
    logic [CW-1:0]         n_reg, n_next;
    logic [IDX_W-1:0]      prod_reg, prod_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic                  drop_reg, drop_next;
    logic [CW-1:0]         issue_cnt_reg, issue_cnt_next;
    logic                  rd_pending_reg, rd_pending_next;
    logic                  out_valid_reg, out_valid_next;
    logic [COL_W-1:0]      out_column_reg, out_column_next;
    logic                  out_dropped_reg, out_dropped_next;

    logic                  item_acc;
    logic [ORDER_X_W-1:0]  nx_eff;
    logic [ORDER_Y_W-1:0]  ny_eff;
    logic [IDX_W-1:0]      ell_full;
    logic [IDX_W-1:0]      idx_sum;
    logic [COL_W-1:0]      base_mul;
    logic                  mod_start;
    logic [ORDER_X_W-1:0]  dvd_x, dvd_y;
    logic                  modx_busy, mody_busy;
    logic [ORDER_X_W-1:0]  rx, ry;
    skip_wr_t              skip_wr;
    logic                  rd_en;
    logic [VALUE_W-1:0]    rd_data;
    logic [BLOCK_W-1:0]    cnt_rd_block;
    logic [CW-1:0]         cnt_rd_data;
    logic                  scan_hit, scan_below;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_x_reg <= ORDER_X_W'(2);
            order_y_reg <= ORDER_Y_W'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_ORDER_X)
                order_x_reg <= cfg_data;
            else if (cfg_index == REG_ORDER_Y)
                order_y_reg <= cfg_data[ORDER_Y_W-1:0];
        end
    end

    assign nx_eff = (order_x_reg == '0) ? ORDER_X_W'(1) : order_x_reg;
    assign ny_eff = (order_y_reg == '0) ? ORDER_Y_W'(1) : order_y_reg;

    assign item_acc   = item.valid && item.ready;
    assign item.ready = (state_reg == ST_IDLE);

    assign dvd_x = ORDER_X_W'(item.shift_x) + ORDER_X_W'(item.term_x);
    assign dvd_y = ORDER_X_W'(item.shift_y) + ORDER_X_W'(item.term_y);

    bmci_mod #(.W(ORDER_X_W)) u_mod_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (dvd_x),
        .divisor  (nx_eff),
        .busy     (modx_busy),
        .rem      (rx)
    );

    bmci_mod #(.W(ORDER_X_W)) u_mod_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (dvd_y),
        .divisor  (ORDER_X_W'(ny_eff)),
        .busy     (mody_busy),
        .rem      (ry)
    );

    always_comb
    begin
        skip_wr.list_we  = item_acc && (item.func == FUNC_SKIP_WR);
        skip_wr.count_we = item_acc && (item.func == FUNC_SKIP_CNT);
        skip_wr.block    = item.block_col;
        skip_wr.slot     = item.skip_slot;
        skip_wr.value    = item.skip_value;
        skip_wr.total    = item.skip_total;
    end

    bmci_skip_store #(
        .BLOCK_COLS (BLOCK_COLS),
        .MAX_SKIP   (MAX_SKIP)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (skip_wr),
        .rd_en        (rd_en),
        .rd_block     (blk_reg),
        .rd_slot      (issue_cnt_reg),
        .rd_data      (rd_data),
        .cnt_rd_block (cnt_rd_block),
        .cnt_rd_data  (cnt_rd_data)
    );

    assign ell_full   = IDX_W'(nx_eff) * IDX_W'(ny_eff);
    assign idx_sum    = IDX_W'(rx) + prod_reg;
    assign base_mul   = COL_W'(blk_reg) * ell_reg;
    assign scan_hit   = (IDX_W'(rd_data) == idx_reg);
    assign scan_below = (IDX_W'(rd_data) < idx_reg);

    always_comb
    begin
        state_next       = state_reg;
        blk_next         = blk_reg;
        sum_next         = sum_reg;
        sum_blk_next     = sum_blk_reg;
        ell_next         = ell_reg;
        n_next           = n_reg;
        prod_next        = prod_reg;
        idx_next         = idx_reg;
        col_next         = col_reg;
        drop_next        = drop_reg;
        issue_cnt_next   = issue_cnt_reg;
        rd_pending_next  = 1'b0;
        out_valid_next   = out_valid_reg;
        out_column_next  = out_column_reg;
        out_dropped_next = out_dropped_reg;
        mod_start        = 1'b0;
        rd_en            = 1'b0;
        cnt_rd_block     = blk_reg;

        if (result.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    blk_next = item.block_col;
                    if (item.func == FUNC_MAP)
                    begin
                        mod_start    = 1'b1;
                        sum_next     = '0;
                        sum_blk_next = '0;
                        state_next   = ST_MOD;
                    end
                    else
                    begin
                        col_next   = '0;
                        drop_next  = 1'b0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MOD:
            begin
                // sum counts of earlier blocks while the remainders run
                cnt_rd_block = sum_blk_reg;
                ell_next     = ell_full[COL_W-1:0];
                if (sum_blk_reg != blk_reg)
                begin
                    sum_next     = sum_reg + SW'(cnt_rd_data);
                    sum_blk_next = sum_blk_reg + BLOCK_W'(1);
                end
                else if (!modx_busy && !mody_busy)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = IDX_W'(nx_eff) * IDX_W'(ry);
                n_next     = cnt_rd_data;
                state_next = ST_BASE;
            end
            ST_BASE:
            begin
                idx_next       = idx_sum;
                col_next       = base_mul - COL_W'(sum_reg) + idx_sum[COL_W-1:0];
                drop_next      = 1'b0;
                issue_cnt_next = '0;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                // read issued one cycle, compared the next
                if (rd_pending_reg && scan_hit)
                begin
                    col_next   = '0;
                    drop_next  = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    if (rd_pending_reg && scan_below)
                        col_next = col_reg - COL_W'(1);
                    if (issue_cnt_reg != n_reg)
                    begin
                        rd_en           = 1'b1;
                        rd_pending_next = 1'b1;
                        issue_cnt_next  = issue_cnt_reg + CW'(1);
                    end
                    else if (!rd_pending_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_column_next  = col_reg;
                    out_dropped_next = drop_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_pending_reg <= rd_pending_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg         <= blk_next;
        sum_blk_reg     <= sum_blk_next;
        sum_reg         <= sum_next;
        ell_reg         <= ell_next;
        n_reg           <= n_next;
        prod_reg        <= prod_next;
        idx_reg         <= idx_next;
        col_reg         <= col_next;
        drop_reg        <= drop_next;
        issue_cnt_reg   <= issue_cnt_next;
        out_column_reg  <= out_column_next;
        out_dropped_reg <= out_dropped_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.column  = out_column_reg;
    assign result.dropped = out_dropped_reg;

    `BMCI_ASSERT_IMP(a_drop_col_zero, result.valid && result.dropped, result.column == '0, "dropped beat carries nonzero column")
    `BMCI_ASSERT_NXT(a_load_to_done, item_acc && item.func != FUNC_MAP, state_reg == ST_DONE, "load item did not go straight to done")
    `BMCI_ASSERT_IMP(a_mul_after_mod, state_reg == ST_MUL, !modx_busy && !mody_busy && sum_blk_reg == blk_reg, "multiply entered before remainders and base sum")
    `BMCI_ASSERT_IMP(a_pending_in_scan, rd_pending_reg, $past(state_reg) == ST_SCAN, "skip read pending outside scan")

endmodule

`default_nettype wire

@@ design/bmci_mod.sv @@
// Iterative remainder unit, one dividend bit per cycle.
`default_nettype none

module bmci_mod #(
    parameter int W = 13
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              busy,
    output logic [W-1:0]      rem
);
    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     dvd_reg, dvd_next;
    logic [W-1:0]     div_reg, div_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W:0]       trial;
    logic [W:0]       diff;

    assign trial = {rem_reg, dvd_reg[W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W);
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // restoring step: partial remainder stays below the divisor
            if (trial >= {1'b0, div_reg})
                rem_next = diff[W-1:0];
            else
                rem_next = trial[W-1:0];
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

@@ design/bmci_skip_store.sv @@
// Skip list memory and per-block skip counts.
`default_nettype none

module bmci_skip_store #(
    parameter int BLOCK_COLS = 8,
    parameter int MAX_SKIP   = 32,
    localparam int CW        = $clog2(MAX_SKIP + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire bmci_pkg::skip_wr_t           wr,
    input  wire logic                         rd_en,
    input  wire logic [bmci_pkg::BLOCK_W-1:0] rd_block,
    input  wire logic [CW-1:0]                rd_slot,
    output logic [bmci_pkg::VALUE_W-1:0]      rd_data,
    input  wire logic [bmci_pkg::BLOCK_W-1:0] cnt_rd_block,
    output logic [CW-1:0]                     cnt_rd_data
);
    import bmci_pkg::*;

    localparam int DEPTH = BLOCK_COLS * MAX_SKIP;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW    = (BLOCK_COLS > 1) ? $clog2(BLOCK_COLS) : 1;

    logic [VALUE_W-1:0] list_mem [DEPTH];
    logic [CW-1:0]      count_reg [BLOCK_COLS];
    logic [VALUE_W-1:0] rd_data_reg;

    logic          wr_blk_ok;
    logic          wr_slot_ok;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] total_sat;

    assign wr_blk_ok  = int'(wr.block) < BLOCK_COLS;
    assign wr_slot_ok = int'(wr.slot) < MAX_SKIP;
    assign wr_addr    = AW'(int'(wr.block) * MAX_SKIP + int'(wr.slot));
    assign rd_addr    = AW'(int'(rd_block) * MAX_SKIP + int'(rd_slot));
    assign total_sat  = (int'(wr.total) > MAX_SKIP) ? CW'(MAX_SKIP) : CW'(wr.total);

    always_ff @(posedge clk)
    begin
        if (wr.list_we && wr_blk_ok && wr_slot_ok)
            list_mem[wr_addr] <= wr.value;
        if (rd_en)
            rd_data_reg <= list_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < BLOCK_COLS; b++)
                count_reg[b] <= '0;
        end
        else if (wr.count_we && wr_blk_ok)
        begin
            count_reg[BW'(wr.block)] <= total_sat;
        end
    end

    // blocks past the stored range have no skips
    assign cnt_rd_data = (int'(cnt_rd_block) < BLOCK_COLS) ? count_reg[BW'(cnt_rd_block)] : '0;
    assign rd_data     = rd_data_reg;

endmodule

`default_nettype wire
